// ===== rtl/emr_pkg.sv =====
// Shared types, constants and command/status structs for the midpoint ellipse rasterizer.
package emr_pkg;

    localparam int AXIS_BITS_DEF = 10;
    localparam int SEMI_X_RST    = 8;
    localparam int SEMI_Y_RST    = 5;

    localparam int OFF_W     = 11;   // offset_x / offset_y
    localparam int CTR_W     = 12;   // center coordinates, 2*x+1 term
    localparam int PT_W      = 13;   // plotted coordinates
    localparam int GR_W      = 36;   // gradients
    localparam int DEC_W     = 48;   // scaled decision term
    localparam int SQ_TERM_W = 24;   // widest square of a 12-bit term
    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 32;

    typedef enum logic [1:0] {
        REG_SEMI_X,
        REG_SEMI_Y,
        REG_CENTER_X,
        REG_CENTER_Y
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_REGION1,
        PH_REGION2,
        PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        ST_WAIT,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_C,
        ST_RS_MUL,
        ST_RS_LOAD,
        ST_STEP,
        ST_DEC,
        ST_EMIT2,
        ST_B_TX,
        ST_B_TXB,
        ST_B_TY,
        ST_B_TYA,
        ST_B_AB,
        ST_B_FIN
    } ctl_state_t;

    typedef enum logic [3:0] {
        MS_NONE,
        MS_AA,
        MS_BB,
        MS_AAB,
        MS_TXTX,
        MS_BBP,
        MS_TYTY,
        MS_AAP,
        MS_AABB
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD4
    } acc_op_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_AA_LOAD,
        OP_BB_LOAD,
        OP_RS_LOAD,
        OP_STEP,
        OP_DEC_STEP,
        OP_DEC_BOUND
    } dp_op_t;

    typedef enum logic [1:0] {
        MIR_PP,
        MIR_NN,
        MIR_PN,
        MIR_NP
    } mirror_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        dp_op_t   op;
        logic     region2;
        logic     clr_stale;
    } dp_cmd_t;

    typedef struct packed {
        logic stale;
        logic grad_lt;
        logic oy_zero;
    } dp_sts_t;

endpackage

// ===== rtl/emr_dp.sv =====
// Datapath: squares cache, shared multiplier, offsets, gradients and decision term.
module emr_dp #(
    parameter int AXIS_BITS = emr_pkg::AXIS_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  emr_pkg::dp_cmd_t           cmd,
    output emr_pkg::dp_sts_t           sts,
    input  logic [AXIS_BITS-1:0]       semi_x,
    input  logic [AXIS_BITS-1:0]       semi_y,
    input  logic                       axis_wr,
    output logic [emr_pkg::OFF_W-1:0]  ox,
    output logic [emr_pkg::OFF_W-1:0]  oy
);
    import emr_pkg::*;

    localparam int SQ_W   = 2 * AXIS_BITS;
    localparam int MUL_W  = (SQ_W > SQ_TERM_W) ? SQ_W : SQ_TERM_W;
    localparam int PROD_W = 2 * MUL_W;

    logic [SQ_W-1:0]   aa_reg, aa_next;
    logic [SQ_W-1:0]   bb_reg, bb_next;
    logic [PROD_W-1:0] prod_reg;
    logic [DEC_W-1:0]  acc_reg, acc_next;
    logic [OFF_W-1:0]  ox_reg, ox_next;
    logic [OFF_W-1:0]  oy_reg, oy_next;
    logic [GR_W-1:0]   gx_reg, gx_next;
    logic [GR_W-1:0]   gy_reg, gy_next;
    logic [DEC_W-1:0]  dec_reg, dec_next;
    logic              inc_x_reg, inc_x_next;
    logic              dec_y_reg, dec_y_next;
    logic              stale_reg, stale_next;

    logic [MUL_W-1:0]  op_a, op_b;
    logic [PROD_W-1:0] mul_full;
    logic [CTR_W-1:0]  tx;
    logic [OFF_W-1:0]  ty_mag;
    logic [DEC_W-1:0]  aa_x, bb_x, gx_x, gy_x, p_lo, b_x;
    logic [DEC_W-1:0]  t1, t2, t3;
    logic [GR_W-1:0]   two_aa, two_bb;
    logic              dec_neg, inc_x, dec_y;

    assign tx      = {ox_reg, 1'b1};
    assign ty_mag  = (oy_reg == '0) ? OFF_W'(1) : (oy_reg - OFF_W'(1));
    assign aa_x    = DEC_W'(aa_reg);
    assign bb_x    = DEC_W'(bb_reg);
    assign gx_x    = DEC_W'(gx_reg);
    assign gy_x    = DEC_W'(gy_reg);
    assign b_x     = DEC_W'(semi_y);
    assign p_lo    = prod_reg[DEC_W-1:0];
    assign two_aa  = GR_W'(aa_x << 1);
    assign two_bb  = GR_W'(bb_x << 1);
    assign dec_neg = dec_reg[DEC_W-1];
    assign inc_x   = cmd.region2 ? dec_neg : 1'b1;
    assign dec_y   = cmd.region2 ? 1'b1 : !dec_neg;

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_sel)
            MS_AA:
            begin
                op_a = MUL_W'(semi_x);
                op_b = MUL_W'(semi_x);
            end
            MS_BB:
            begin
                op_a = MUL_W'(semi_y);
                op_b = MUL_W'(semi_y);
            end
            MS_AAB:
            begin
                op_a = MUL_W'(aa_reg);
                op_b = MUL_W'(semi_y);
            end
            MS_TXTX:
            begin
                op_a = MUL_W'(tx);
                op_b = MUL_W'(tx);
            end
            MS_BBP:
            begin
                op_a = MUL_W'(bb_reg);
                op_b = MUL_W'(prod_reg[SQ_TERM_W-1:0]);
            end
            MS_TYTY:
            begin
                op_a = MUL_W'(ty_mag);
                op_b = MUL_W'(ty_mag);
            end
            MS_AAP:
            begin
                op_a = MUL_W'(aa_reg);
                op_b = MUL_W'(prod_reg[SQ_TERM_W-1:0]);
            end
            MS_AABB:
            begin
                op_a = MUL_W'(aa_reg);
                op_b = MUL_W'(bb_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_full = op_a * op_b;

    always_comb
    begin
        t1 = cmd.region2 ? aa_x : bb_x;
        t2 = inc_x_reg ? gx_x : '0;
        t3 = dec_y_reg ? gy_x : '0;

        aa_next    = aa_reg;
        bb_next    = bb_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        gx_next    = gx_reg;
        gy_next    = gy_reg;
        dec_next   = dec_reg;
        inc_x_next = inc_x_reg;
        dec_y_next = dec_y_reg;

        case (cmd.op)
            OP_AA_LOAD: aa_next = prod_reg[SQ_W-1:0];
            OP_BB_LOAD: bb_next = prod_reg[SQ_W-1:0];
            OP_RS_LOAD:
            begin
                ox_next  = '0;
                oy_next  = b_x[OFF_W-1:0];
                gx_next  = '0;
                gy_next  = {prod_reg[GR_W-2:0], 1'b0};
                dec_next = (bb_x << 2) - (p_lo << 2) + aa_x;
            end
            OP_STEP:
            begin
                inc_x_next = inc_x;
                dec_y_next = dec_y;
                if (inc_x)
                begin
                    ox_next = ox_reg + OFF_W'(1);
                    gx_next = gx_reg + two_bb;
                end
                if (dec_y)
                begin
                    oy_next = oy_reg - OFF_W'(1);
                    gy_next = gy_reg - two_aa;
                end
            end
            // gradients are already updated here
            OP_DEC_STEP:  dec_next = dec_reg + ((t1 + t2) << 2) - (t3 << 2);
            OP_DEC_BOUND: dec_next = acc_reg - (p_lo << 2);
            default:      dec_next = dec_reg;
        endcase

        case (cmd.acc_op)
            ACC_LOAD: acc_next = p_lo;
            ACC_ADD4: acc_next = acc_reg + (p_lo << 2);
            default:  acc_next = acc_reg;
        endcase

        // a write during a squares rebuild leaves the flag set, so it runs again
        if (axis_wr)
            stale_next = 1'b1;
        else if (cmd.clr_stale)
            stale_next = 1'b0;
        else
            stale_next = stale_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg <= 1'b1;
            inc_x_reg <= 1'b0;
            dec_y_reg <= 1'b0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            gx_reg    <= '0;
            gy_reg    <= '0;
            dec_reg   <= '0;
        end
        else
        begin
            stale_reg <= stale_next;
            inc_x_reg <= inc_x_next;
            dec_y_reg <= dec_y_next;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            gx_reg    <= gx_next;
            gy_reg    <= gy_next;
            dec_reg   <= dec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        aa_reg   <= aa_next;
        bb_reg   <= bb_next;
        acc_reg  <= acc_next;
        prod_reg <= mul_full;
    end

    assign ox          = ox_reg;
    assign oy          = oy_reg;
    assign sts.stale   = stale_reg;
    assign sts.grad_lt = gx_reg < gy_reg;
    assign sts.oy_zero = (oy_reg == '0);

endmodule

// ===== rtl/emr_emit.sv =====
// Emitter: holds one position, sends its four mirrored points one per unstalled cycle.
module emr_emit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic [emr_pkg::OFF_W-1:0]         ox,
    input  logic [emr_pkg::OFF_W-1:0]         oy,
    input  logic [emr_pkg::CTR_W-1:0]         center_x,
    input  logic [emr_pkg::CTR_W-1:0]         center_y,
    output logic                              free,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [emr_pkg::PT_W-1:0]   point_x,
    output logic signed [emr_pkg::PT_W-1:0]   point_y,
    output logic                              group_last,
    output logic                              final_point
);
    import emr_pkg::*;

    logic             busy_reg, busy_next;
    mirror_t          idx_reg, idx_next;
    logic [OFF_W-1:0] ox_reg, oy_reg;
    logic             fin_reg;

    logic             fire, last, neg_x, neg_y;
    logic [PT_W-1:0]  ox_ext, oy_ext, sx, sy, hx, ky;

    assign fire  = busy_reg && !out_stall;
    assign last  = (idx_reg == MIR_NP);
    assign free  = !busy_reg || (fire && last);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = MIR_PP;
        end
        else if (fire)
        begin
            if (last)
                busy_next = 1'b0;
            else
                idx_next = mirror_t'(idx_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= MIR_PP;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ox_reg  <= ox;
            oy_reg  <= oy;
            fin_reg <= (oy == '0);
        end
    end

    // mirror order: (x,y) (-x,-y) (x,-y) (-x,y)
    assign neg_x  = (idx_reg == MIR_NN) || (idx_reg == MIR_NP);
    assign neg_y  = (idx_reg == MIR_NN) || (idx_reg == MIR_PN);
    assign ox_ext = PT_W'(ox_reg);
    assign oy_ext = PT_W'(oy_reg);
    assign sx     = neg_x ? (PT_W'(0) - ox_ext) : ox_ext;
    assign sy     = neg_y ? (PT_W'(0) - oy_ext) : oy_ext;
    assign hx     = {center_x[CTR_W-1], center_x};
    assign ky     = {center_y[CTR_W-1], center_y};

    assign out_valid   = busy_reg;
    assign point_x     = hx + sx;
    assign point_y     = ky + sy;
    assign group_last  = last;
    assign final_point = fin_reg;

endmodule

// ===== rtl/emr_ctrl.sv =====
// Controller: sequences squares rebuild, restart, region steps and the boundary products.
module emr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              restart,
    output logic              in_stall,
    input  emr_pkg::dp_sts_t  sts,
    output emr_pkg::dp_cmd_t  cmd,
    input  logic              em_free,
    output logic              em_load
);
    import emr_pkg::*;

    ctl_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cmd.mul_sel   = MS_NONE;
        cmd.acc_op    = ACC_HOLD;
        cmd.op        = OP_NONE;
        cmd.region2   = (phase_reg == PH_REGION2);
        cmd.clr_stale = 1'b0;
        em_load       = 1'b0;
        ready         = 1'b0;

        case (state_reg)
            ST_WAIT:
            begin
                if (sts.stale)
                    state_next = ST_SQ_A;
                else
                begin
                    // region 1 snapshots its position into the emitter on accept
                    ready = restart || (phase_reg != PH_REGION1) || em_free;
                    if (in_valid && ready)
                    begin
                        if (restart)
                            state_next = ST_RS_MUL;
                        else
                        begin
                            case (phase_reg)
                                PH_REGION1:
                                begin
                                    em_load    = 1'b1;
                                    state_next = sts.grad_lt ? ST_STEP : ST_B_TX;
                                end
                                PH_REGION2: state_next = ST_STEP;
                                default:    state_next = ST_WAIT;
                            endcase
                        end
                    end
                end
            end
            ST_SQ_A:
            begin
                cmd.mul_sel   = MS_AA;
                cmd.clr_stale = 1'b1;
                state_next    = ST_SQ_B;
            end
            ST_SQ_B:
            begin
                cmd.op      = OP_AA_LOAD;
                cmd.mul_sel = MS_BB;
                state_next  = ST_SQ_C;
            end
            ST_SQ_C:
            begin
                cmd.op     = OP_BB_LOAD;
                state_next = ST_WAIT;
            end
            ST_RS_MUL:
            begin
                cmd.mul_sel = MS_AAB;
                state_next  = ST_RS_LOAD;
            end
            ST_RS_LOAD:
            begin
                cmd.op     = OP_RS_LOAD;
                phase_next = PH_REGION1;
                state_next = ST_WAIT;
            end
            ST_STEP:
            begin
                cmd.op     = OP_STEP;
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                cmd.op     = OP_DEC_STEP;
                state_next = (phase_reg == PH_REGION2) ? ST_EMIT2 : ST_WAIT;
            end
            ST_EMIT2:
            begin
                if (em_free)
                begin
                    em_load    = 1'b1;
                    phase_next = sts.oy_zero ? PH_DONE : PH_REGION2;
                    state_next = ST_WAIT;
                end
            end
            ST_B_TX:
            begin
                cmd.mul_sel = MS_TXTX;
                state_next  = ST_B_TXB;
            end
            ST_B_TXB:
            begin
                cmd.mul_sel = MS_BBP;
                state_next  = ST_B_TY;
            end
            ST_B_TY:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MS_TYTY;
                state_next  = ST_B_TYA;
            end
            ST_B_TYA:
            begin
                cmd.mul_sel = MS_AAP;
                state_next  = ST_B_AB;
            end
            ST_B_AB:
            begin
                cmd.acc_op  = ACC_ADD4;
                cmd.mul_sel = MS_AABB;
                state_next  = ST_B_FIN;
            end
            ST_B_FIN:
            begin
                cmd.op     = OP_DEC_BOUND;
                phase_next = sts.oy_zero ? PH_DONE : PH_REGION2;
                state_next = ST_WAIT;
            end
            default: state_next = ST_WAIT;
        endcase

        in_stall = !ready;
    end

endmodule

// ===== rtl/ellipse_rasterizer_midpoint_core.sv =====
// Top level of the midpoint ellipse rasterizer: register port, controller, datapath, emitter.
//
// A restart transfer loads (0,b) from the semi-axis registers in states RS_MUL and
// RS_LOAD and produces no points; each advance transfer produces the next position as
// four mirrored points, one result per cycle while out_stall is low, the fourth flagged
// group_last and all four flagged final_point on the last position. The position rate in
// both regions is set by the four-point output stage: the gradient and decision update
// runs while the previous group drains. The single boundary position between the regions
// adds states B_TX to B_FIN on the one shared multiplier (five products, partly chained).
// After reset and after any semi-axis register write, the cached squares a*a and b*b are
// rebuilt in states SQ_A, SQ_B and SQ_C, which holds off the next input transfer. Advance
// transfers before the first restart or after the final group are taken and do nothing.
module ellipse_rasterizer_midpoint_core #(
    parameter int AXIS_BITS = emr_pkg::AXIS_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [emr_pkg::CFG_AW-1:0]         paddr,
    input  logic [emr_pkg::CFG_DW-1:0]         pwdata,
    output logic [emr_pkg::CFG_DW-1:0]         prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               restart,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [emr_pkg::PT_W-1:0]    point_x,
    output logic signed [emr_pkg::PT_W-1:0]    point_y,
    output logic                               group_last,
    output logic                               final_point
);
    import emr_pkg::*;

    logic [AXIS_BITS-1:0] semi_x_reg, semi_y_reg;
    logic [CTR_W-1:0]     center_x_reg, center_y_reg;
    reg_idx_t             reg_idx;
    logic                 cfg_wr, axis_wr;

    dp_cmd_t              dp_cmd;
    dp_sts_t              dp_sts;
    logic                 em_free, em_load;
    logic [OFF_W-1:0]     ox, oy;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign axis_wr = cfg_wr && ((reg_idx == REG_SEMI_X) || (reg_idx == REG_SEMI_Y));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            semi_x_reg   <= AXIS_BITS'(SEMI_X_RST);
            semi_y_reg   <= AXIS_BITS'(SEMI_Y_RST);
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_SEMI_X:   semi_x_reg   <= pwdata[AXIS_BITS-1:0];
                REG_SEMI_Y:   semi_y_reg   <= pwdata[AXIS_BITS-1:0];
                REG_CENTER_X: center_x_reg <= pwdata[CTR_W-1:0];
                REG_CENTER_Y: center_y_reg <= pwdata[CTR_W-1:0];
                default:      center_y_reg <= center_y_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SEMI_X:   prdata = CFG_DW'(semi_x_reg);
            REG_SEMI_Y:   prdata = CFG_DW'(semi_y_reg);
            REG_CENTER_X: prdata = CFG_DW'(center_x_reg);
            REG_CENTER_Y: prdata = CFG_DW'(center_y_reg);
            default:      prdata = '0;
        endcase
    end

    emr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .restart  (restart),
        .in_stall (in_stall),
        .sts      (dp_sts),
        .cmd      (dp_cmd),
        .em_free  (em_free),
        .em_load  (em_load)
    );

    emr_dp #(
        .AXIS_BITS (AXIS_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (dp_cmd),
        .sts     (dp_sts),
        .semi_x  (semi_x_reg),
        .semi_y  (semi_y_reg),
        .axis_wr (axis_wr),
        .ox      (ox),
        .oy      (oy)
    );

    emr_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (em_load),
        .ox          (ox),
        .oy          (oy),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .free        (em_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .group_last  (group_last),
        .final_point (final_point)
    );

    // a new group never overwrites one that is still draining
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        em_load |-> em_free)
        else $error("emitter loaded while a group is still pending");

    // no transfer is taken while the cached squares are out of date
    a_no_stale_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !dp_sts.stale)
        else $error("input transfer taken with stale squares");

    // within a group the final flag does not change
    a_group_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !group_last) |=>
            (out_valid && (final_point == $past(final_point))))
        else $error("group broken or final flag changed inside a group");

endmodule

// ===== test/emr_point_checker.sv =====
// Checker for the ellipse rasterizer: follows register writes, predicts plotted points, compares.
module emr_point_checker #(
    parameter int AXIS_BITS = emr_pkg::AXIS_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [emr_pkg::CFG_AW-1:0]      paddr,
    input  logic [emr_pkg::CFG_DW-1:0]      pwdata,
    input  logic                            pready,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            restart,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic signed [emr_pkg::PT_W-1:0] point_x,
    input  logic signed [emr_pkg::PT_W-1:0] point_y,
    input  logic                            group_last,
    input  logic                            final_point,
    output int                              errors,
    output int                              pending,
    output logic                            drawing
);
    timeunit 1ns;
    timeprecision 1ps;

    import emr_pkg::*;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic                   last;
        logic                   fin;
    } plot_pt_t;

    plot_pt_t             due_points[$];

    logic [AXIS_BITS-1:0] axis_a;
    logic [AXIS_BITS-1:0] axis_b;
    logic [CTR_W-1:0]     ctr_h;
    logic [CTR_W-1:0]     ctr_k;
    phase_t               ph;
    logic [OFF_W-1:0]     ox;
    logic [OFF_W-1:0]     oy;
    logic [DEC_W-1:0]     dec;
    logic [GR_W-1:0]      gx;
    logic [GR_W-1:0]      gy;

    initial
    begin
        errors  = 0;
        pending = 0;
        drawing = 1'b0;
    end

    task automatic report(input string msg);
        errors++;
        $error("%s", msg);
    endtask

    // four mirrored points of the current position
    task automatic plot_group();
        plot_pt_t        pt;
        mirror_t         m;
        logic [PT_W-1:0] h13;
        logic [PT_W-1:0] k13;
        logic [PT_W-1:0] dx;
        logic [PT_W-1:0] dy;
        h13 = {ctr_h[CTR_W-1], ctr_h};
        k13 = {ctr_k[CTR_W-1], ctr_k};
        dx  = PT_W'(ox);
        dy  = PT_W'(oy);
        for (int i = 0; i < 4; i++)
        begin
            m       = mirror_t'(i);
            pt.x    = (m == MIR_PP || m == MIR_PN) ? h13 + dx : h13 - dx;
            pt.y    = (m == MIR_PP || m == MIR_NP) ? k13 + dy : k13 - dy;
            pt.last = (m == MIR_NP);
            pt.fin  = (oy == '0);
            due_points.push_back(pt);
        end
    endtask

    // one accepted command; all sums in 64 bits, then cut to the register widths
    task automatic trace_step(input logic rs);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] aa;
        logic [63:0] bb;
        logic [63:0] tx;
        logic [63:0] ty;
        logic [63:0] t;
        a  = 64'(axis_a);
        b  = 64'(axis_b);
        aa = a * a;
        bb = b * b;
        if (rs)
        begin
            ox  = '0;
            oy  = b[OFF_W-1:0];
            gx  = '0;
            t   = 64'd2 * aa * b;
            gy  = t[GR_W-1:0];
            t   = 64'd4 * bb - 64'd4 * aa * b + aa;
            dec = t[DEC_W-1:0];
            ph  = PH_REGION1;
        end
        else if (ph == PH_REGION1)
        begin
            plot_group();
            if (gx < gy)
            begin
                ox = ox + 1'b1;
                t  = 64'(gx) + 64'd2 * bb;
                gx = t[GR_W-1:0];
                if (dec[DEC_W-1])
                begin
                    t = 64'(dec) + 64'd4 * (64'(gx) + bb);
                end
                else
                begin
                    oy = oy - 1'b1;
                    t  = 64'(gy) - 64'd2 * aa;
                    gy = t[GR_W-1:0];
                    t  = 64'(dec) + 64'd4 * (64'(gx) + bb) - 64'd4 * 64'(gy);
                end
                dec = t[DEC_W-1:0];
            end
            else
            begin
                // boundary position: decision rebuilt at (x + 1/2, y - 1)
                tx  = 64'd2 * 64'(ox) + 64'd1;
                ty  = 64'(oy) - 64'd1;
                t   = bb * tx * tx + 64'd4 * aa * ty * ty - 64'd4 * aa * bb;
                dec = t[DEC_W-1:0];
                ph  = (oy == '0) ? PH_DONE : PH_REGION2;
            end
        end
        else if (ph == PH_REGION2)
        begin
            oy = oy - 1'b1;
            t  = 64'(gy) - 64'd2 * aa;
            gy = t[GR_W-1:0];
            if (!dec[DEC_W-1])
            begin
                t = 64'(dec) + 64'd4 * aa - 64'd4 * 64'(gy);
            end
            else
            begin
                ox = ox + 1'b1;
                t  = 64'(gx) + 64'd2 * bb;
                gx = t[GR_W-1:0];
                t  = 64'(dec) + 64'd4 * (64'(gx) + aa) - 64'd4 * 64'(gy);
            end
            dec = t[DEC_W-1:0];
            if (oy == '0)
            begin
                ph = PH_DONE;
            end
            plot_group();
        end
    endtask

    task automatic check_point();
        plot_pt_t want;
        if (due_points.size() == 0)
        begin
            report($sformatf("unexpected point (%0d, %0d) with nothing due",
                             point_x, point_y));
        end
        else
        begin
            want = due_points.pop_front();
            if (point_x !== want.x)
            begin
                report($sformatf("point_x: expected %0d, got %0d",
                                 $signed(want.x), point_x));
            end
            if (point_y !== want.y)
            begin
                report($sformatf("point_y: expected %0d, got %0d",
                                 $signed(want.y), point_y));
            end
            if (group_last !== want.last)
            begin
                report($sformatf("group_last: expected %0b, got %0b",
                                 want.last, group_last));
            end
            if (final_point !== want.fin)
            begin
                report($sformatf("final_point: expected %0b, got %0b",
                                 want.fin, final_point));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_a = AXIS_BITS'(SEMI_X_RST);
            axis_b = AXIS_BITS'(SEMI_Y_RST);
            ctr_h  = '0;
            ctr_k  = '0;
            ph     = PH_IDLE;
            ox     = '0;
            oy     = '0;
            dec    = '0;
            gx     = '0;
            gy     = '0;
            due_points.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_point();
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_SEMI_X:   axis_a = pwdata[AXIS_BITS-1:0];
                    REG_SEMI_Y:   axis_b = pwdata[AXIS_BITS-1:0];
                    REG_CENTER_X: ctr_h  = pwdata[CTR_W-1:0];
                    REG_CENTER_Y: ctr_k  = pwdata[CTR_W-1:0];
                    default:      ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                trace_step(restart);
            end
        end
        pending = due_points.size();
        drawing = (ph == PH_REGION1 || ph == PH_REGION2);
    end

endmodule

// ===== test/tb_ellipse_rasterizer_midpoint_core.sv =====
// Testbench top for the ellipse rasterizer: clock, reset, register writes, commands, verdict.
module tb_ellipse_rasterizer_midpoint_core;
    timeunit 1ns;
    timeprecision 1ps;

    import emr_pkg::*;

    localparam int TOTAL_ITEMS    = 110;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 32;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_AW-1:0]      paddr;
    logic [CFG_DW-1:0]      pwdata;
    logic [CFG_DW-1:0]      prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_stall;
    logic                   restart;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic                   group_last;
    logic                   final_point;
    int                     errors;
    int                     pending;
    logic                   drawing;

    logic                   calm;
    logic                   sink_hold;
    int                     sent_items;
    int                     quiet_cycles = 0;

    ellipse_rasterizer_midpoint_core i_dut (.*);

    emr_point_checker i_chk (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pause_len();
        if ($urandom_range(0, 99) < 80)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    function automatic int unsigned pick_axis();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            return 1;
        end
        if (r == 1)
        begin
            return 1023;
        end
        if (r == 2)
        begin
            return $urandom_range(0, 1023);
        end
        if (r == 3)
        begin
            return 0;
        end
        return $urandom_range(1, 12);
    endfunction

    function automatic int unsigned pick_center();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 12'h800;
        end
        if (r == 1)
        begin
            return 12'h7FF;
        end
        return $urandom_range(0, 4095);
    endfunction

    // entered and left at a falling edge
    task automatic reg_write(input reg_idx_t idx, input logic [CFG_DW-1:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_shape(input int unsigned a, input int unsigned b,
                             input int unsigned h, input int unsigned k);
        reg_write(REG_SEMI_X, a);
        reg_write(REG_SEMI_Y, b);
        reg_write(REG_CENTER_X, h);
        reg_write(REG_CENTER_Y, k);
    endtask

    // one command transfer
    task automatic issue_step(input logic rs);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pause_len();
        sent_items++;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        restart  = rs;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic walk_arc(input int max_steps, input int noise_pct);
        int steps;
        steps = 0;
        while (drawing && steps < max_steps && sent_items < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                issue_step(1'($urandom_range(0, 1)));
            end
            else
            begin
                issue_step(1'b0);
            end
            steps++;
        end
        repeat ($urandom_range(0, 2)) issue_step(1'b0);
    endtask

    task automatic trace_ellipse(input int max_steps, input int noise_pct);
        issue_step(1'b1);
        walk_arc(max_steps, noise_pct);
    endtask

    // block goes idle: every due point out, then room for a boundary or square rebuild
    task automatic wait_plot_drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
                sink_hold = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall = 1'b1;
                repeat (pause_len()) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_ellipse_rasterizer_midpoint_core: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        int          ph_n;
        int unsigned a;
        int unsigned b;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        restart    = 1'b0;
        calm       = 1'b0;
        sink_hold  = 1'b0;
        sent_items = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // advances before any restart do nothing
        issue_step(1'b0);
        issue_step(1'b0);
        // reset shape, full outline, then an advance past the end
        trace_ellipse(40, 0);
        issue_step(1'b0);
        wait_plot_drain();

        // flat ellipse: the boundary group at the origin is already final
        reg_write(REG_SEMI_X, 3);
        reg_write(REG_SEMI_Y, 0);
        issue_step(1'b1);
        issue_step(1'b0);
        issue_step(1'b0);
        wait_plot_drain();

        // zero width: straight vertical run, centers at the extremes
        set_shape(0, 3, 12'h800, 12'h7FF);
        trace_ellipse(20, 0);
        wait_plot_drain();

        // widest axes, first few positions only
        set_shape(1023, 1023, 12'h7FF, 12'h800);
        trace_ellipse(3, 0);
        wait_plot_drain();

        // long output hold-off while commands keep coming, so the block backs up
        set_shape(24, 16, 12'h010, 12'hFF0);
        calm      = 1'b1;
        sink_hold = 1'b1;
        trace_ellipse(25, 0);
        wait_plot_drain();
        calm = 1'b0;

        for (ph_n = 0; sent_items < TOTAL_ITEMS; ph_n++)
        begin
            a = pick_axis();
            b = pick_axis();
            set_shape(a, b, pick_center(), pick_center());
            calm = ($urandom_range(0, 4) == 0);
            if (ph_n % 4 == 1)
            begin
                // registers changed halfway through an outline
                trace_ellipse(3, 0);
                wait_plot_drain();
                reg_write(REG_SEMI_X, $urandom_range(2, 10));
                reg_write(REG_CENTER_Y, pick_center());
                walk_arc(80, 0);
            end
            else
            begin
                trace_ellipse((a > 40 || b > 40) ? 8 : 80, 8);
            end
            wait_plot_drain();
        end
        calm = 1'b0;

        wait_plot_drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
        begin
            $display("tb_ellipse_rasterizer_midpoint_core: done, clean");
        end
        else
        begin
            $display("tb_ellipse_rasterizer_midpoint_core: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/emr_pkg.sv
rtl/emr_dp.sv
rtl/emr_emit.sv
rtl/emr_ctrl.sv
rtl/ellipse_rasterizer_midpoint_core.sv
test/emr_point_checker.sv
test/tb_ellipse_rasterizer_midpoint_core.sv
